// ===== src/ngd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ngd_pkg;

    localparam int MaxLen    = 32;
    localparam int MaxGram   = 4;
    localparam int GramSlots = MaxLen + 2;
    localparam int AddrW     = $clog2(MaxLen);
    localparam int LenW      = $clog2(MaxLen + 1);
    localparam int KW        = (MaxGram > 1) ? $clog2(MaxGram) : 1;
    localparam int NW        = $clog2(MaxGram + 1);
    localparam int SlotW     = $clog2(GramSlots + 1);
    localparam int TotalW    = $clog2(2 * GramSlots + 1);
    localparam int MatchW    = 6;
    localparam int DistW     = 7;
    localparam int DiceW     = 17;
    localparam int NumW      = SlotW + 1 + 16;
    localparam int CntW      = $clog2(NumW + 1);
    localparam logic [7:0] PadChar = 8'h20;

    localparam logic CfgGramSize  = 1'b0;
    localparam logic CfgThreshold = 1'b1;

    typedef struct packed {
        logic accept;
        logic init;
        logic ci_next;
        logic di_next;
        logic match;
        logic k_next;
        logic rd;
        logic div_start;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic di_end;
        logic di_used;
        logic char_eq;
        logic k_last;
        logic div_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ===== src/ngd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ngd_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic           s_tuser,
    input  wire logic           s_tlast,
    input  wire ngd_pkg::status_t sts,
    output ngd_pkg::cmd_t       cmd
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StInit = 3'd1;
    localparam logic [2:0] StScan = 3'd2;
    localparam logic [2:0] StRead = 3'd3;
    localparam logic [2:0] StCmp  = 3'd4;
    localparam logic [2:0] StDiv  = 3'd5;
    localparam logic [2:0] StFin  = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == StIdle);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            StIdle: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (s_tuser && s_tlast) begin
                        state_next = StInit;
                    end
                end
            end
            StInit: begin
                cmd.init = 1'b1;
                state_next = StScan;
            end
            StScan: begin
                if (sts.scan_done) begin
                    cmd.div_start = 1'b1;
                    state_next = StDiv;
                end else if (sts.di_end) begin
                    cmd.ci_next = 1'b1;
                end else if (sts.di_used) begin
                    cmd.di_next = 1'b1;
                end else begin
                    state_next = StRead;
                end
            end
            StRead: begin
                cmd.rd = 1'b1;
                state_next = StCmp;
            end
            StCmp: begin
                if (!sts.char_eq) begin
                    cmd.di_next = 1'b1;
                    state_next = StScan;
                end else if (sts.k_last) begin
                    cmd.match = 1'b1;
                    state_next = StScan;
                end else begin
                    cmd.k_next = 1'b1;
                    state_next = StRead;
                end
            end
            StDiv: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = StFin;
                end
            end
            StFin: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next = StIdle;
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/ngd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ngd_datapath (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ngd_pkg::cmd_t    cmd,
    output ngd_pkg::status_t      sts,
    input  wire logic             in_sel,
    input  wire logic             in_valid,
    input  wire logic [7:0]       in_code,
    input  wire logic             in_last,
    input  wire logic             cfg_we,
    input  wire logic             cfg_idx,
    input  wire logic [16:0]      cfg_val,
    input  wire logic             out_take,
    output logic                  out_valid,
    output logic [ngd_pkg::MatchW-1:0] out_match,
    output logic [ngd_pkg::DistW-1:0]  out_dist,
    output logic [ngd_pkg::DiceW-1:0]  out_dice,
    output logic                  out_above,
    output logic                  out_ovf
);

    logic [7:0] cand_mem [ngd_pkg::MaxLen];
    logic [7:0] dict_mem [ngd_pkg::MaxLen];

    logic [ngd_pkg::LenW-1:0]   cand_len_reg, dict_len_reg, cand_base;
    logic                       closed_reg;
    logic [1:0]                 ovf_reg;
    logic [2:0]                 gram_size_reg;
    logic [16:0]                thr_reg;
    logic [ngd_pkg::NW-1:0]     n_reg, n_eff;
    logic [ngd_pkg::SlotW-1:0]  gc_reg, gd_reg, ci_reg, di_reg, gc_next, gd_next;
    logic [ngd_pkg::KW-1:0]     k_reg;
    logic [ngd_pkg::GramSlots-1:0] used_reg;
    logic [ngd_pkg::MatchW-1:0] match_reg;
    logic                       cpad_reg, dpad_reg;
    logic [7:0]                 cdata_reg, ddata_reg, cchar, dchar;
    logic [ngd_pkg::SlotW:0]    cpos, dpos, cpad_lim, dpad_lim;
    logic [ngd_pkg::AddrW-1:0]  caddr, daddr;
    logic [ngd_pkg::TotalW-1:0] total;
    logic [ngd_pkg::TotalW-1:0] rem_reg;
    logic [ngd_pkg::TotalW:0]   rem_sh;
    logic [ngd_pkg::NumW-1:0]   num_reg;
    logic [ngd_pkg::CntW-1:0]   cnt_reg;
    logic [ngd_pkg::DiceW-1:0]  dice;
    logic                       out_valid_reg;
    logic [ngd_pkg::MatchW-1:0] out_match_reg;
    logic [ngd_pkg::DistW-1:0]  out_dist_reg;
    logic [ngd_pkg::DiceW-1:0]  out_dice_reg;
    logic                       out_above_reg, out_ovf_reg;

    function automatic logic [ngd_pkg::SlotW-1:0] grams(
        input logic [ngd_pkg::LenW-1:0] len, input logic [ngd_pkg::NW-1:0] n);
        logic [ngd_pkg::SlotW-1:0] padded;
        padded = ngd_pkg::SlotW'(len) + ngd_pkg::SlotW'(2);
        if (padded >= ngd_pkg::SlotW'(n)) begin
            return padded - ngd_pkg::SlotW'(n) + ngd_pkg::SlotW'(1);
        end
        return '0;
    endfunction

    always_comb begin
        if (gram_size_reg == 3'd0) begin
            n_eff = ngd_pkg::NW'(1);
        end else if (32'(gram_size_reg) > ngd_pkg::MaxGram) begin
            n_eff = ngd_pkg::NW'(ngd_pkg::MaxGram);
        end else begin
            n_eff = ngd_pkg::NW'(gram_size_reg);
        end
    end

    assign gc_next   = grams(cand_len_reg, n_eff);
    assign gd_next   = grams(dict_len_reg, n_eff);
    assign cand_base = closed_reg ? '0 : cand_len_reg;

    assign cpos     = (ngd_pkg::SlotW+1)'(ci_reg) + (ngd_pkg::SlotW+1)'(k_reg);
    assign dpos     = (ngd_pkg::SlotW+1)'(di_reg) + (ngd_pkg::SlotW+1)'(k_reg);
    assign cpad_lim = (ngd_pkg::SlotW+1)'(cand_len_reg);
    assign dpad_lim = (ngd_pkg::SlotW+1)'(dict_len_reg);
    assign caddr    = ngd_pkg::AddrW'(cpos - 1'b1);
    assign daddr    = ngd_pkg::AddrW'(dpos - 1'b1);
    assign cchar    = cpad_reg ? ngd_pkg::PadChar : cdata_reg;
    assign dchar    = dpad_reg ? ngd_pkg::PadChar : ddata_reg;

    assign total  = ngd_pkg::TotalW'(gc_reg) + ngd_pkg::TotalW'(gd_reg);
    assign rem_sh = {rem_reg, num_reg[ngd_pkg::NumW-1]};
    assign dice   = (total == '0) ? '0 : num_reg[ngd_pkg::DiceW-1:0];

    always_comb begin
        sts.scan_done = (ci_reg == gc_reg);
        sts.di_end    = (di_reg == gd_reg);
        sts.di_used   = used_reg[di_reg];
        sts.char_eq   = (cchar == dchar);
        sts.k_last    = (ngd_pkg::NW'(k_reg) == n_reg - 1'b1);
        sts.div_last  = (cnt_reg == ngd_pkg::CntW'(1));
        sts.out_free  = !out_valid_reg || out_take;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && in_valid) begin
            if (!in_sel && (32'(cand_base) < ngd_pkg::MaxLen)) begin
                cand_mem[ngd_pkg::AddrW'(cand_base)] <= in_code;
            end
            if (in_sel && (32'(dict_len_reg) < ngd_pkg::MaxLen)) begin
                dict_mem[ngd_pkg::AddrW'(dict_len_reg)] <= in_code;
            end
        end
        if (cmd.rd) begin
            cdata_reg <= cand_mem[caddr];
            ddata_reg <= dict_mem[daddr];
            cpad_reg  <= (cpos == '0) || (cpos > cpad_lim);
            dpad_reg  <= (dpos == '0) || (dpos > dpad_lim);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_len_reg  <= '0;
            dict_len_reg  <= '0;
            closed_reg    <= 1'b1;
            ovf_reg       <= '0;
            gram_size_reg <= 3'd2;
            thr_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    ngd_pkg::CfgGramSize:  gram_size_reg <= cfg_val[2:0];
                    ngd_pkg::CfgThreshold: thr_reg       <= cfg_val;
                    default: begin
                    end
                endcase
            end
            if (cmd.accept) begin
                if (!in_sel) begin
                    closed_reg <= in_last;
                    if (in_valid && (32'(cand_base) < ngd_pkg::MaxLen)) begin
                        cand_len_reg <= cand_base + 1'b1;
                        ovf_reg[0]   <= closed_reg ? 1'b0 : ovf_reg[0];
                    end else begin
                        cand_len_reg <= cand_base;
                        ovf_reg[0]   <= (closed_reg ? 1'b0 : ovf_reg[0]) | in_valid;
                    end
                end else begin
                    closed_reg <= 1'b1;
                    if (in_valid) begin
                        if (32'(dict_len_reg) < ngd_pkg::MaxLen) begin
                            dict_len_reg <= dict_len_reg + 1'b1;
                        end else begin
                            ovf_reg[1] <= 1'b1;
                        end
                    end
                end
            end
            if (cmd.init) begin
                used_reg <= '0;
            end
            if (cmd.match) begin
                used_reg[di_reg] <= 1'b1;
            end
            if (cmd.load_out) begin
                dict_len_reg <= '0;
                ovf_reg[1]   <= 1'b0;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            n_reg     <= n_eff;
            gc_reg    <= gc_next;
            gd_reg    <= gd_next;
            ci_reg    <= '0;
            di_reg    <= '0;
            k_reg     <= '0;
            match_reg <= '0;
        end
        if (cmd.ci_next) begin
            ci_reg <= ci_reg + 1'b1;
            di_reg <= '0;
        end
        if (cmd.di_next) begin
            di_reg <= di_reg + 1'b1;
            k_reg  <= '0;
        end
        if (cmd.match) begin
            match_reg <= match_reg + 1'b1;
            ci_reg    <= ci_reg + 1'b1;
            di_reg    <= '0;
            k_reg     <= '0;
        end
        if (cmd.k_next) begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            num_reg <= {ngd_pkg::SlotW'(match_reg), 17'd0};
            cnt_reg <= ngd_pkg::CntW'(ngd_pkg::NumW);
        end
        if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (rem_sh >= {1'b0, total}) begin
                rem_reg <= ngd_pkg::TotalW'(rem_sh - {1'b0, total});
                num_reg <= {num_reg[ngd_pkg::NumW-2:0], 1'b1};
            end else begin
                rem_reg <= ngd_pkg::TotalW'(rem_sh);
                num_reg <= {num_reg[ngd_pkg::NumW-2:0], 1'b0};
            end
        end
        if (cmd.load_out) begin
            out_match_reg <= match_reg;
            out_dist_reg  <= ngd_pkg::DistW'(total - {ngd_pkg::TotalW'(match_reg), 1'b0});
            out_dice_reg  <= dice;
            out_above_reg <= (dice > thr_reg);
            out_ovf_reg   <= (ovf_reg != 2'b00);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_match = out_match_reg;
    assign out_dist  = out_dist_reg;
    assign out_dice  = out_dice_reg;
    assign out_above = out_above_reg;
    assign out_ovf   = out_ovf_reg;

endmodule
`default_nettype wire

// ===== src/ngram_dice_similarity.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Scores a dictionary word against a stored candidate word by character n-gram Dice
// similarity. Candidate and dictionary characters are taken one character per cycle; the
// dictionary word that carries tlast starts scoring, during which no input is taken.
// Scoring compares gram pairs one character at a time through the two character
// memories, then runs a bit-serial divide. The result waits in an output register.
module ngram_dice_similarity (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // char_valid, char_code, zero fill
    input  wire logic        s_tuser,  // word_select
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // match_count, gram_distance, dice_q16,
                                       // above_threshold, length_overflow
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data
);

    ngd_pkg::cmd_t    cmd;
    ngd_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    ngd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    ngd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_sel    (s_tuser),
        .in_valid  (s_tdata[0]),
        .in_code   (s_tdata[8:1]),
        .in_last   (s_tlast),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_val   (cfg_data),
        .out_take  (m_tready),
        .out_valid (m_tvalid),
        .out_match (m_tdata[5:0]),
        .out_dist  (m_tdata[12:6]),
        .out_dice  (m_tdata[29:13]),
        .out_above (m_tdata[30]),
        .out_ovf   (m_tdata[31])
    );

    a_score_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser && s_tlast) |=> !s_tready)
        else $error("input taken while scoring");

    a_dice_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:13] <= 17'h10000))
        else $error("Dice above one");

    a_match_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] <= 6'd34))
        else $error("match count out of range");

endmodule
`default_nettype wire
